// ----- hw/rtl/tyc_pkg.sv -----
// ----------------------------------------------------------------------------
// Time-of-year converter package
// Shared item types, pipeline control types, calendar constants and tables.
// ----------------------------------------------------------------------------
package tyc_pkg;

    localparam int NSTG = 9;

    localparam logic [24:0] SECS_PER_YEAR = 25'd31536000;
    localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
    localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
    localparam logic [5:0]  SECS_PER_MIN  = 6'd60;

    // Ceiling or floor reciprocals of the odd parts of the divisors.
    localparam logic [14:0] YEAR_RECIP = 15'd17432;
    localparam logic [18:0] DAY_RECIP  = 19'd397683;
    localparam logic [12:0] HOUR_RECIP = 13'd4661;
    localparam logic [10:0] MIN_RECIP  = 11'd1093;

    localparam logic [3:0] NUM_MONTHS = 4'd12;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_CLOCK = 2'd2
    } status_t;

    typedef struct packed {
        logic        mode;
        logic [31:0] seconds_in;
        logic [7:0]  month_in;
        logic [7:0]  day_in;
        logic [4:0]  hour_in;
        logic [5:0]  minute_in;
        logic [5:0]  second_in;
        logic        time_valid;
        logic        clock_enabled;
    } in_item_t;

    typedef struct packed {
        logic [24:0] seconds_out;
        logic [3:0]  month_out;
        logic [4:0]  day_out;
        logic [4:0]  hour_out;
        logic [5:0]  minute_out;
        logic [5:0]  second_out;
        status_t     status;
    } out_item_t;

    typedef struct packed {
        logic [NSTG-1:0] en;
        logic [NSTG-1:0] vld;
    } ctrl_t;

    typedef struct packed {
        logic [24:0] seconds;
        status_t     status;
    } compose_res_t;

    typedef struct packed {
        logic [3:0] month;
        logic [4:0] day;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } split_res_t;

    function automatic logic [8:0] month_start(input logic [3:0] idx);
        logic [8:0] v;
        case (idx)
            4'd0:    v = 9'd0;
            4'd1:    v = 9'd31;
            4'd2:    v = 9'd59;
            4'd3:    v = 9'd90;
            4'd4:    v = 9'd120;
            4'd5:    v = 9'd151;
            4'd6:    v = 9'd181;
            4'd7:    v = 9'd212;
            4'd8:    v = 9'd243;
            4'd9:    v = 9'd273;
            4'd10:   v = 9'd304;
            4'd11:   v = 9'd334;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

endpackage

// ----- hw/rtl/tyc_ctrl.sv -----
// ----------------------------------------------------------------------------
// Time-of-year converter pipeline control
// Stage valid bits, per-stage load enables with bubble collapsing, mode line.
// ----------------------------------------------------------------------------
module tyc_ctrl import tyc_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    output logic  s_ready,
    input  logic  s_mode,
    output logic  m_valid,
    input  logic  m_ready,
    output logic  mode_out,
    output ctrl_t ctrl
);

    logic [NSTG-1:0] valid_reg;
    logic [NSTG-1:0] valid_next;
    logic [NSTG-1:0] en;
    logic            mode_reg [NSTG];

    always_comb begin
        en[NSTG-1] = !valid_reg[NSTG-1] || m_ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            en[k] = !valid_reg[k] || en[k+1];
        end
    end

    always_comb begin
        for (int k = 0; k < NSTG; k++) begin
            if (en[k]) begin
                valid_next[k] = (k == 0) ? s_valid : valid_reg[(k == 0) ? 0 : k - 1];
            end else begin
                valid_next[k] = valid_reg[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            mode_reg[0] <= s_mode;
        end
        for (int k = 1; k < NSTG; k++) begin
            if (en[k]) begin
                mode_reg[k] <= mode_reg[k-1];
            end
        end
    end

    assign s_ready  = en[0];
    assign m_valid  = valid_reg[NSTG-1];
    assign mode_out = mode_reg[NSTG-1];
    assign ctrl.en  = en;
    assign ctrl.vld = valid_reg;

    a_full_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (&valid_reg) && !m_ready |-> !s_ready)
        else $error("input accepted while every stage is full and the output stalls");

    a_item_count: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> ($countones(valid_reg) == $past($countones(valid_reg))
            + $past(s_valid && s_ready) - $past(m_valid && m_ready)))
        else $error("items lost or duplicated in the pipeline");

endmodule

// ----- hw/rtl/tyc_compose.sv -----
// ----------------------------------------------------------------------------
// Time-of-year converter compose path
// Builds seconds of year from month, day and clock fields, with status.
// ----------------------------------------------------------------------------
module tyc_compose import tyc_pkg::*; (
    input  logic         aclk,
    input  ctrl_t        ctrl,
    input  in_item_t     in_item,
    output compose_res_t res
);

    status_t     status0_reg, status0_next;
    logic [8:0]  dayidx0_reg, dayidx0_next;
    logic [16:0] hms0_reg, hms0_next;
    status_t     status1_reg;
    logic [24:0] cd1_reg, cd1_next;
    logic [16:0] hms1_reg;
    compose_res_t line_reg [2:NSTG-1];
    compose_res_t line2_next;

    always_comb begin
        logic mon_ok;
        logic day_ok;
        mon_ok = (in_item.month_in >= 8'd1) && (in_item.month_in <= {4'd0, NUM_MONTHS});
        day_ok = (in_item.day_in >= 8'd1) && (in_item.day_in <= 8'd31);
        if (!in_item.time_valid || !in_item.clock_enabled) begin
            status0_next = ST_CLOCK;
        end else if (!mon_ok || !day_ok) begin
            status0_next = ST_RANGE;
        end else begin
            status0_next = ST_OK;
        end
        dayidx0_next = month_start(in_item.month_in[3:0] - 4'd1)
                     + {4'd0, in_item.day_in[4:0]} - 9'd1;
        hms0_next = 17'({12'd0, in_item.hour_in} * {5'd0, SECS_PER_HOUR})
                  + 17'({11'd0, in_item.minute_in} * {11'd0, SECS_PER_MIN})
                  + {11'd0, in_item.second_in};
    end

    assign cd1_next = 25'({16'd0, dayidx0_reg} * {8'd0, SECS_PER_DAY});

    always_comb begin
        line2_next.status = status1_reg;
        if (status1_reg == ST_OK) begin
            line2_next.seconds = cd1_reg + {8'd0, hms1_reg};
        end else begin
            line2_next.seconds = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.en[0]) begin
            status0_reg <= status0_next;
            dayidx0_reg <= dayidx0_next;
            hms0_reg    <= hms0_next;
        end
        if (ctrl.en[1]) begin
            status1_reg <= status0_reg;
            cd1_reg     <= cd1_next;
            hms1_reg    <= hms0_reg;
        end
        if (ctrl.en[2]) begin
            line_reg[2] <= line2_next;
        end
        for (int k = 3; k < NSTG; k++) begin
            if (ctrl.en[k]) begin
                line_reg[k] <= line_reg[k-1];
            end
        end
    end

    assign res = line_reg[NSTG-1];

endmodule

// ----- hw/rtl/tyc_split.sv -----
// ----------------------------------------------------------------------------
// Time-of-year converter split path
// Reduces seconds modulo one year and splits them into calendar fields.
// ----------------------------------------------------------------------------
module tyc_split import tyc_pkg::*; (
    input  logic       aclk,
    input  ctrl_t      ctrl,
    input  logic [31:0] seconds_in,
    output split_res_t res
);

    logic [31:0] x0_reg;
    logic [7:0]  q0_reg, q0_next;
    logic [25:0] r1_reg, r1_next;
    logic [24:0] t2_reg, t2_next;
    logic [24:0] t3_reg;
    logic [8:0]  d3_reg, d3_next;
    logic [16:0] rest4_reg, rest4_next;
    logic [3:0]  mon4_reg, mon4_next;
    logic [4:0]  dom4_reg, dom4_next;
    logic [16:0] rest5_reg;
    logic [4:0]  h5_reg, h5_next;
    logic [11:0] rem6_reg, rem6_next;
    logic [11:0] rem7_reg;
    logic [5:0]  mi7_reg, mi7_next;
    logic [5:0]  se8_reg, se8_next;
    logic [3:0]  mon_reg [5:8];
    logic [4:0]  dom_reg [5:8];
    logic [4:0]  h_reg   [6:8];
    logic [5:0]  mi8_reg;

    logic [39:0] p0;
    logic [36:0] p3;
    logic [25:0] p5;
    logic [20:0] p7;

    assign p0      = {15'd0, seconds_in[31:7]} * {25'd0, YEAR_RECIP};
    assign q0_next = p0[39:32];

    assign r1_next = 26'(x0_reg - ({24'd0, q0_reg} * {7'd0, SECS_PER_YEAR}));

    assign t2_next = (r1_reg >= {1'b0, SECS_PER_YEAR}) ? 25'(r1_reg - {1'b0, SECS_PER_YEAR})
                                                       : r1_reg[24:0];

    assign p3      = {19'd0, t2_reg[24:7]} * {18'd0, DAY_RECIP};
    assign d3_next = p3[36:28];

    always_comb begin
        logic [3:0] cnt;
        cnt = 4'd1;
        for (int k = 1; k < 12; k++) begin
            if (d3_reg >= month_start(4'(k))) begin
                cnt = cnt + 4'd1;
            end
        end
        mon4_next  = cnt;
        dom4_next  = 5'(d3_reg - month_start(cnt - 4'd1) + 9'd1);
        rest4_next = 17'(t3_reg - 25'({16'd0, d3_reg} * {8'd0, SECS_PER_DAY}));
    end

    assign p5      = {13'd0, rest4_reg[16:4]} * {13'd0, HOUR_RECIP};
    assign h5_next = p5[24:20];

    assign rem6_next = 12'(rest5_reg - 17'({12'd0, h5_reg} * {5'd0, SECS_PER_HOUR}));

    assign p7       = {11'd0, rem6_reg[11:2]} * {10'd0, MIN_RECIP};
    assign mi7_next = p7[19:14];

    assign se8_next = 6'(rem7_reg - 12'({6'd0, mi7_reg} * {6'd0, SECS_PER_MIN}));

    always_ff @(posedge aclk) begin
        if (ctrl.en[0]) begin
            x0_reg <= seconds_in;
            q0_reg <= q0_next;
        end
        if (ctrl.en[1]) begin
            r1_reg <= r1_next;
        end
        if (ctrl.en[2]) begin
            t2_reg <= t2_next;
        end
        if (ctrl.en[3]) begin
            t3_reg <= t2_reg;
            d3_reg <= d3_next;
        end
        if (ctrl.en[4]) begin
            rest4_reg <= rest4_next;
            mon4_reg  <= mon4_next;
            dom4_reg  <= dom4_next;
        end
        if (ctrl.en[5]) begin
            rest5_reg  <= rest4_reg;
            h5_reg     <= h5_next;
            mon_reg[5] <= mon4_reg;
            dom_reg[5] <= dom4_reg;
        end
        if (ctrl.en[6]) begin
            rem6_reg <= rem6_next;
            h_reg[6] <= h5_reg;
        end
        if (ctrl.en[7]) begin
            rem7_reg <= rem6_reg;
            mi7_reg  <= mi7_next;
            h_reg[7] <= h_reg[6];
        end
        if (ctrl.en[8]) begin
            se8_reg  <= se8_next;
            mi8_reg  <= mi7_reg;
            h_reg[8] <= h_reg[7];
        end
        for (int k = 6; k < NSTG; k++) begin
            if (ctrl.en[k]) begin
                mon_reg[k] <= mon_reg[k-1];
                dom_reg[k] <= dom_reg[k-1];
            end
        end
    end

    assign res.month  = mon_reg[8];
    assign res.day    = dom_reg[8];
    assign res.hour   = h_reg[8];
    assign res.minute = mi8_reg;
    assign res.second = se8_reg;

    a_date_range: assert property (@(posedge aclk)
        ctrl.vld[4] |-> (mon4_reg >= 4'd1) && (mon4_reg <= NUM_MONTHS)
            && (dom4_reg >= 5'd1) && (dom4_reg <= 5'd31))
        else $error("month or day of the split out of range");

    a_time_range: assert property (@(posedge aclk)
        ctrl.vld[8] |-> (h_reg[8] <= 5'd23) && (mi8_reg <= 6'd59) && (se8_reg <= 6'd59))
        else $error("hour, minute or second of the split out of range");

endmodule

// ----- hw/rtl/time_of_year_converter.sv -----
// ----------------------------------------------------------------------------
// Throughput: one item per cycle unless m_ready stalls a full pipeline; set by a
// nine-stage pipeline with a reciprocal multiply for each constant division.
// Reset clears the valid bit of every stage; data registers are not reset.
// ----------------------------------------------------------------------------
// Time-of-year converter
// Composes or splits seconds of a non-leap year in a nine-stage pipeline.
// ----------------------------------------------------------------------------
module time_of_year_converter import tyc_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    ctrl_t        ctrl;
    logic         mode;
    compose_res_t comp;
    split_res_t   spl;

    tyc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_mode   (s_data.mode),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .mode_out (mode),
        .ctrl     (ctrl)
    );

    tyc_compose u_compose (
        .aclk    (aclk),
        .ctrl    (ctrl),
        .in_item (s_data),
        .res     (comp)
    );

    tyc_split u_split (
        .aclk       (aclk),
        .ctrl       (ctrl),
        .seconds_in (s_data.seconds_in),
        .res        (spl)
    );

    always_comb begin
        if (mode) begin
            m_data.seconds_out = '0;
            m_data.month_out   = spl.month;
            m_data.day_out     = spl.day;
            m_data.hour_out    = spl.hour;
            m_data.minute_out  = spl.minute;
            m_data.second_out  = spl.second;
            m_data.status      = ST_OK;
        end else begin
            m_data.seconds_out = comp.seconds;
            m_data.month_out   = '0;
            m_data.day_out     = '0;
            m_data.hour_out    = '0;
            m_data.minute_out  = '0;
            m_data.second_out  = '0;
            m_data.status      = comp.status;
        end
    end

endmodule
